@@ sv/bpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bpd_pkg
// shared types, constants and the keyword string rom of the detokenizer
// ----------------------------------------------------------------------------
package bpd_pkg;

    // configuration port
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_PROGRAM_LENGTH = '0;

    // stream constants
    localparam logic [7:0]  REM_TOKEN    = 8'd234;
    localparam logic [7:0]  NUMBER_MARK  = 8'd14;
    localparam logic [2:0]  NUMBER_BYTES = 3'd5;
    localparam logic [15:0] END_MARGIN   = 16'd3;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0]  CHAR_QMARK   = 8'h3F;

    // string rom geometry: longest entry is ten characters
    localparam int TOKEN_CHARS = 10;
    localparam int TEXT_W      = 8 * TOKEN_CHARS;
    localparam int LEN_W       = $clog2(TOKEN_CHARS + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_NUMBER,
        CMD_NEWLINE,
        CMD_TOKEN
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] data;
    } cmd_t;

    // right-aligned text of one code, zero padded on the left
    function automatic logic [TEXT_W-1:0] token_text(input logic [7:0] code);
        logic [TEXT_W-1:0] t;
        t = '0;
        case (code) inside
            8'd92:            t = "\\\\";
            [8'd32:8'd126]:   t = {{(TEXT_W-8){1'b0}}, code};
            8'd127:           t = "\\@";
            8'd128:           t = "\\  ";
            8'd129:           t = "\\ '";
            8'd130:           t = "\\' ";
            8'd131:           t = "\\''";
            8'd132:           t = "\\ .";
            8'd133:           t = "\\ :";
            8'd134:           t = "\\'.";
            8'd135:           t = "\\':";
            8'd136:           t = "\\. ";
            8'd137:           t = "\\.'";
            8'd138:           t = "\\: ";
            8'd139:           t = "\\:'";
            8'd140:           t = "\\..";
            8'd141:           t = "\\.:";
            8'd142:           t = "\\:.";
            8'd143:           t = "\\::";
            // user graphics: backslash and a letter a to s
            [8'd144:8'd162]:  t = {{(TEXT_W-16){1'b0}}, CHAR_BSLASH, 8'(code - 8'd47)};
            8'd163:           t = " SPECTRUM ";
            8'd164:           t = " PLAY ";
            8'd165:           t = "RND";
            8'd166:           t = "INKEY$";
            8'd167:           t = "PI";
            8'd168:           t = "FN ";
            8'd169:           t = "POINT ";
            8'd170:           t = "SCREEN$ ";
            8'd171:           t = "ATTR ";
            8'd172:           t = "AT ";
            8'd173:           t = "TAB ";
            8'd174:           t = "VAL$ ";
            8'd175:           t = "CODE ";
            8'd176:           t = "VAL ";
            8'd177:           t = "LEN ";
            8'd178:           t = "SIN ";
            8'd179:           t = "COS ";
            8'd180:           t = "TAN ";
            8'd181:           t = "ASN ";
            8'd182:           t = "ACS ";
            8'd183:           t = "ATN ";
            8'd184:           t = "LN ";
            8'd185:           t = "EXP ";
            8'd186:           t = "INT ";
            8'd187:           t = "SQR ";
            8'd188:           t = "SGN ";
            8'd189:           t = "ABS ";
            8'd190:           t = "PEEK ";
            8'd191:           t = "IN ";
            8'd192:           t = "USR ";
            8'd193:           t = "STR$ ";
            8'd194:           t = "CHR$ ";
            8'd195:           t = "NOT ";
            8'd196:           t = "BIN ";
            8'd197:           t = " OR ";
            8'd198:           t = " AND ";
            8'd199:           t = "<=";
            8'd200:           t = ">=";
            8'd201:           t = "<>";
            8'd202:           t = " LINE ";
            8'd203:           t = " THEN";
            8'd204:           t = " TO ";
            8'd205:           t = " STEP ";
            8'd206:           t = " DEF FN ";
            8'd207:           t = " CAT ";
            8'd208:           t = " FORMAT ";
            8'd209:           t = " MOVE ";
            8'd210:           t = " ERASE ";
            8'd211:           t = " OPEN#";
            8'd212:           t = " CLOSE#";
            8'd213:           t = " MERGE ";
            8'd214:           t = " VERIFY ";
            8'd215:           t = " BEEP ";
            8'd216:           t = " CIRCLE ";
            8'd217:           t = " INK ";
            8'd218:           t = " PAPER ";
            8'd219:           t = " FLASH ";
            8'd220:           t = " BRIGHT ";
            8'd221:           t = " INVERSE ";
            8'd222:           t = " OVER ";
            8'd223:           t = " OUT ";
            8'd224:           t = " LPRINT ";
            8'd225:           t = " LLIST ";
            8'd226:           t = " STOP ";
            8'd227:           t = " READ ";
            8'd228:           t = " DATA ";
            8'd229:           t = " RESTORE ";
            8'd230:           t = " NEW ";
            8'd231:           t = " BORDER ";
            8'd232:           t = " CONTINUE ";
            8'd233:           t = " DIM ";
            8'd234:           t = " REM ";
            8'd235:           t = " FOR ";
            8'd236:           t = " GOTO ";
            8'd237:           t = " GOSUB ";
            8'd238:           t = " INPUT ";
            8'd239:           t = " LOAD ";
            8'd240:           t = " LIST ";
            8'd241:           t = " LET ";
            8'd242:           t = " PAUSE ";
            8'd243:           t = " NEXT ";
            8'd244:           t = " POKE ";
            8'd245:           t = " PRINT ";
            8'd246:           t = " PLOT ";
            8'd247:           t = " RUN ";
            8'd248:           t = " SAVE ";
            8'd249:           t = " RANDOMIZE";
            8'd250:           t = " IF ";
            8'd251:           t = " CLS ";
            8'd252:           t = " DRAW ";
            8'd253:           t = " CLEAR ";
            8'd254:           t = " RETURN";
            8'd255:           t = " COPY ";
            default:          t = {{(TEXT_W-8){1'b0}}, CHAR_QMARK};
        endcase
        return t;
    endfunction

    // number of characters in a right-aligned entry
    function automatic logic [LEN_W-1:0] token_len(input logic [TEXT_W-1:0] t);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < TOKEN_CHARS; i++)
        begin
            if (t[8*i +: 8] != 8'h00)
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/bpd_if.sv @@
// ----------------------------------------------------------------------------
// bpd stream interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface bpd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

@@ sv/bpd_front.sv @@
// ----------------------------------------------------------------------------
// bpd_front
// line parser: takes program bytes and turns each into at most one command
// ----------------------------------------------------------------------------
module bpd_front
    import bpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr,
    input  logic [15:0]  cfg_length,
    bpd_byte_if.sink     bytes,
    input  logic         q_full,
    output logic         push,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        PH_NUM_HI,
        PH_NUM_LO,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  number_hi_reg, number_hi_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] line_length_reg, line_length_next;
    logic [15:0] position_reg, position_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [2:0]  skip_reg, skip_next;
    logic        rem_line_reg, rem_line_next;

    logic        accept;
    logic [15:0] rem_dec;
    phase_t      end_phase;
    logic        is_rem;
    logic [15:0] new_length;

    assign bytes.ready = !q_full;
    assign accept      = bytes.valid && bytes.ready;
    assign rem_dec     = (remaining_reg != 16'd0) ? remaining_reg - 16'd1 : 16'd0;
    assign end_phase   = (rem_dec > END_MARGIN) ? PH_NUM_HI : PH_DONE;
    assign new_length  = {bytes.in_byte, len_lo_reg};
    assign is_rem      = (position_reg == 16'd0) ? (bytes.in_byte == REM_TOKEN) : rem_line_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        number_hi_next   = number_hi_reg;
        len_lo_next      = len_lo_reg;
        line_length_next = line_length_reg;
        position_next    = position_reg;
        remaining_next   = remaining_reg;
        skip_next        = skip_reg;
        rem_line_next    = rem_line_reg;
        push             = 1'b0;
        cmd.op           = CMD_TOKEN;
        cmd.data         = {8'h00, bytes.in_byte};

        if (accept)
        begin
            unique case (phase_reg)
                PH_NUM_HI:
                begin
                    remaining_next = rem_dec;
                    number_hi_next = bytes.in_byte;
                    phase_next     = PH_NUM_LO;
                end
                PH_NUM_LO:
                begin
                    remaining_next = rem_dec;
                    push           = 1'b1;
                    cmd.op         = CMD_NUMBER;
                    cmd.data       = {number_hi_reg, bytes.in_byte};
                    phase_next     = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    remaining_next = rem_dec;
                    len_lo_next    = bytes.in_byte;
                    phase_next     = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    remaining_next   = rem_dec;
                    line_length_next = new_length;
                    position_next    = 16'd0;
                    skip_next        = 3'd0;
                    rem_line_next    = 1'b0;
                    if (new_length == 16'd0)
                    begin
                        push       = 1'b1;
                        cmd.op     = CMD_NEWLINE;
                        phase_next = end_phase;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    remaining_next = rem_dec;
                    rem_line_next  = is_rem;
                    if (({1'b0, position_reg} + 17'd1) >= {1'b0, line_length_reg})
                    begin
                        // last body byte always closes the line
                        push       = 1'b1;
                        cmd.op     = CMD_NEWLINE;
                        skip_next  = 3'd0;
                        phase_next = end_phase;
                    end
                    else if (skip_reg != 3'd0)
                    begin
                        skip_next = skip_reg - 3'd1;
                    end
                    else if (!is_rem && bytes.in_byte == NUMBER_MARK)
                    begin
                        skip_next = NUMBER_BYTES;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                    position_next = position_reg + 16'd1;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // a length write restarts parsing
        if (cfg_wr)
        begin
            phase_next     = PH_NUM_HI;
            remaining_next = cfg_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_NUM_HI;
            number_hi_reg   <= 8'h00;
            len_lo_reg      <= 8'h00;
            line_length_reg <= 16'd0;
            position_reg    <= 16'd0;
            remaining_reg   <= 16'd0;
            skip_reg        <= 3'd0;
            rem_line_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            number_hi_reg   <= number_hi_next;
            len_lo_reg      <= len_lo_next;
            line_length_reg <= line_length_next;
            position_reg    <= position_next;
            remaining_reg   <= remaining_next;
            skip_reg        <= skip_next;
            rem_line_reg    <= rem_line_next;
        end
    end

    // a finished listing never issues commands
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> !push)
        else $error("command issued after end of program");

    // skip count never exceeds the inline number size
    assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= NUMBER_BYTES)
        else $error("skip count out of range");

    // nothing is pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push while queue full");

endmodule

@@ sv/bpd_queue.sv @@
// ----------------------------------------------------------------------------
// bpd_queue
// small command fifo between the parser and the expander
// ----------------------------------------------------------------------------
module bpd_queue
    import bpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  wr_cmd,
    output logic  full,
    input  logic  pop,
    output cmd_t  rd_cmd,
    output logic  empty
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

    // fill level tracks the pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != (QPTR_W+1)'(QUEUE_DEPTH)) |-> (QPTR_W'(count_reg) == wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

@@ sv/bpd_back.sv @@
// ----------------------------------------------------------------------------
// bpd_back
// expander: turns commands into result beats, while results is ready one character per cycle
// ----------------------------------------------------------------------------
module bpd_back
    import bpd_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          q_cmd,
    input  logic          q_empty,
    output logic          pop,
    bpd_result_if.source  results
);

    localparam int CNT_W = $clog2(MAX_TOKEN_CHARS + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              kind_reg, kind_next;
    logic [15:0]       num_reg, num_next;
    logic [TEXT_W-1:0] text_reg, text_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [15:0]       out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;

    logic              move;
    logic [15:0]       head_value;
    logic [TEXT_W-1:0] rom_text;
    logic [LEN_W-1:0]  rom_len;

    assign head_value = kind_reg ? num_reg : {8'h00, text_reg[TEXT_W-1 -: 8]};
    assign move       = (cnt_reg != '0) && (!out_valid_reg || results.ready);
    assign pop        = !q_empty && ((cnt_reg == '0) || (cnt_reg == CNT_W'(1) && move));
    assign rom_text   = token_text(q_cmd.data[7:0]);
    assign rom_len    = token_len(rom_text);

    always_comb
    begin
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        num_next       = num_reg;
        text_next      = text_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (move)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = kind_reg;
            out_value_next = head_value;
            out_last_next  = (cnt_reg == CNT_W'(1));
            text_next      = text_reg << 8;
            cnt_next       = cnt_reg - 1'b1;
        end
        else if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            case (q_cmd.op)
                CMD_NUMBER:
                begin
                    kind_next = 1'b1;
                    num_next  = q_cmd.data;
                    cnt_next  = CNT_W'(1);
                end
                CMD_NEWLINE:
                begin
                    kind_next = 1'b0;
                    text_next = {NEWLINE_CODE, {(TEXT_W-8){1'b0}}};
                    cnt_next  = CNT_W'(1);
                end
                default:
                begin
                    // left-align the entry so the head character is on top
                    kind_next = 1'b0;
                    text_next = rom_text << (8 * (TOKEN_CHARS - int'(rom_len)));
                    if (int'(rom_len) > MAX_TOKEN_CHARS)
                    begin
                        cnt_next = CNT_W'(MAX_TOKEN_CHARS);
                    end
                    else
                    begin
                        cnt_next = CNT_W'(rom_len);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        text_reg      <= text_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid = out_valid_reg;
    assign results.kind  = out_kind_reg;
    assign results.value = out_value_reg;
    assign results.last  = out_last_reg;

    // every loaded command yields at least one beat
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (cnt_reg != '0))
        else $error("empty expansion loaded");

    // a line number is a single beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg && cnt_reg != '0) |-> (cnt_reg == CNT_W'(1)))
        else $error("line number spans several beats");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind) |-> results.last)
        else $error("line number beat not marked last");

endmodule

@@ sv/basic_program_detokenizer.sv @@
// ----------------------------------------------------------------------------
// basic_program_detokenizer
// turns a tokenized basic program byte stream into a listing of result beats
// ----------------------------------------------------------------------------
// Write program_length over the apb port (byte address 0) while the block is
// idle; the write also restarts parsing at a line header. Bytes are taken on
// the input channel one per cycle whenever the four-entry command queue has
// room; header bytes give only the line-number beat (and the newline of an
// empty line) and skipped bytes give none. Each line gives one line-number
// beat (kind 1), the body expands to text beats (kind 0) and ends in a
// newline beat; last marks the final beat of a command. The expander emits one
// beat per cycle while results is ready, from a left-aligned rom word, so a
// command stays in the back end until its last beat, and the next command loads
// under that last beat; throughput is limited by the single-character
// output path.
// ----------------------------------------------------------------------------
module basic_program_detokenizer
    import bpd_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // streams
    bpd_byte_if.sink          bytes,
    bpd_result_if.source      results
);

    logic [15:0] program_length_reg, program_length_next;
    logic        cfg_wr;
    logic        reg_hit;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    cmd_t        q_wr_cmd;
    cmd_t        q_rd_cmd;

    // register decode: word index sits above the byte offset
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_PROGRAM_LENGTH);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? {16'h0000, program_length_reg} : 32'h0000_0000;

    assign program_length_next = cfg_wr ? pwdata[15:0] : program_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg <= 16'd0;
        end
        else
        begin
            program_length_reg <= program_length_next;
        end
    end

    // front: header parsing, inline number skip, classification
    bpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .cfg_length (pwdata[15:0]),
        .bytes      (bytes),
        .q_full     (q_full),
        .push       (q_push),
        .cmd        (q_wr_cmd)
    );

    // decouples byte intake from character output
    bpd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (q_wr_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .rd_cmd (q_rd_cmd),
        .empty  (q_empty)
    );

    // back: rom lookup and one beat per cycle, when results is ready, into the output register
    bpd_back #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_rd_cmd),
        .q_empty (q_empty),
        .pop     (q_pop),
        .results (results)
    );

endmodule
